// ===== design/tmse_pkg.sv =====
// ----------------------------------------------------------------------------
// tmse_pkg
// Shared types and constants for the Turing machine step engine.
// ----------------------------------------------------------------------------
package tmse_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_SYMBOLS = 16;
    localparam int TAPE_CELLS  = 1024;

    localparam int STATE_W    = 4;
    localparam int SYM_W      = 4;
    localparam int MOVE_W     = 2;
    localparam int TAPE_AW    = 10;
    localparam int RULE_AW    = STATE_W + SYM_W;
    localparam int RULE_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int STEP_W     = 16;
    localparam int STATUS_W   = 3;

    localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);
    localparam logic [STEP_W-1:0]  MAX_STEPS_RST = 16'd1000;
    localparam logic [STATE_W-1:0] STATE_HALT  = 4'd0;
    localparam logic [STATE_W-1:0] STATE_START = 4'd1;

    // Commands.
    localparam logic [1:0] CMD_LOAD_RULE = 2'd0;
    localparam logic [1:0] CMD_LOAD_CELL = 2'd1;
    localparam logic [1:0] CMD_START     = 2'd2;
    localparam logic [1:0] CMD_STEP      = 2'd3;

    // Head moves.
    localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_RUN    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NORULE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEFT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RIGHT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LIMIT  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd6;

    typedef struct packed {
        logic [1:0]         command;
        logic [STATE_W-1:0] rule_state;
        logic [SYM_W-1:0]   rule_symbol;
        logic [SYM_W-1:0]   write_symbol;
        logic [MOVE_W-1:0]  head_move;
        logic [STATE_W-1:0] next_state;
        logic               rule_defined;
        logic [TAPE_AW-1:0] cell_index;
        logic [SYM_W-1:0]   cell_symbol;
        logic [TAPE_AW-1:0] head_start;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STATE_W-1:0]  state_now;
        logic [TAPE_AW-1:0]  head_now;
        logic [SYM_W-1:0]    read_symbol;
        logic [SYM_W-1:0]    written_symbol;
        logic [STEP_W-1:0]   steps_done;
    } t_out_item;

    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic [MOVE_W-1:0]  move;
        logic [STATE_W-1:0] next;
    } t_rule_entry;

    typedef struct packed {
        logic               en;
        logic [TAPE_AW-1:0] addr;
        logic [SYM_W-1:0]   data;
    } t_tape_wr;

    typedef struct packed {
        logic               en;
        logic [RULE_AW-1:0] addr;
        t_rule_entry        entry;
        logic               defined;
    } t_rule_wr;

endpackage

// ===== design/tmse_tape_ram.sv =====
// ----------------------------------------------------------------------------
// tmse_tape_ram
// Tape memory, one symbol per cell, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module tmse_tape_ram
    import tmse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tape_wr           i_wr,
    input  logic [TAPE_AW-1:0] i_raddr,
    output logic [SYM_W-1:0]   o_rdata,
    output logic               o_clr_busy
);

    logic [SYM_W-1:0]   r_mem [TAPE_CELLS];
    logic [SYM_W-1:0]   r_rdata;
    logic               r_clr_busy;
    logic [TAPE_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == TAPE_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // The sweep owns the write port until every cell holds the blank symbol.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

// ===== design/tmse_rule_ram.sv =====
// ----------------------------------------------------------------------------
// tmse_rule_ram
// Transition rule memory indexed by {state, symbol}, with defined flags.
// ----------------------------------------------------------------------------
module tmse_rule_ram
    import tmse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rule_wr           i_wr,
    input  logic [RULE_AW-1:0] i_raddr,
    output t_rule_entry        o_rdata,
    output logic               o_rdef
);

    t_rule_entry            r_mem [RULE_DEPTH];
    logic [RULE_DEPTH-1:0]  r_def;
    t_rule_entry            r_rdata;
    logic                   r_rdef;

    // The defined flags clear at reset, so no rule exists until loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def  <= '0;
            r_rdef <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_def[i_wr.addr] <= i_wr.defined;
            end
            r_rdef <= r_def[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_rdef  = r_rdef;

endmodule

// ===== design/turing_machine_step_engine_core.sv =====
// ----------------------------------------------------------------------------
// turing_machine_step_engine_core
// Single-tape Turing machine: rule and tape loads, run start and single steps.
// ----------------------------------------------------------------------------
//  channel   direction  signals                            payload
//  in        input      i_in_valid / o_in_ready            t_in_item
//  out       output     o_out_valid / i_out_ready          t_out_item
//  cfg       input      i_cfg_we / i_cfg_data              max_steps
//
//  A load or run start has its result beat registered at accept.
//  A step runs as accept and tape read, then rule read, then write-back and result;
//  the tape read data forms the rule read address, so the two reads come in order.
//  After reset a clearing pass blanks the tape, and no items are accepted until it ends.
//  A new item is accepted only when the output register is empty or being taken.
// ----------------------------------------------------------------------------
module turing_machine_step_engine_core
    import tmse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic [STEP_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TAPE = 2'd1;
    localparam logic [1:0] S_RULE = 2'd2;

    logic [1:0]          r_fsm, n_fsm;
    logic [STATE_W-1:0]  r_mstate, n_mstate;
    logic [TAPE_AW-1:0]  r_head, n_head;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic                r_running, n_running;
    logic [SYM_W-1:0]    r_rd, n_rd;
    logic [STEP_W-1:0]   r_max_steps;
    logic                r_out_vld, n_out_vld;
    t_out_item           r_out, n_out;

    logic                in_acc;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic [SYM_W-1:0]    emit_rd;
    logic [SYM_W-1:0]    emit_wr;
    logic [STATUS_W-1:0] step_status;

    t_tape_wr            tape_wr;
    logic [SYM_W-1:0]    tape_rdata;
    logic                clr_busy;
    t_rule_wr            rule_wr;
    t_rule_entry         rule_rdata;
    logic                rule_rdef;

    tmse_tape_ram u_tape (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tape_wr),
        .i_raddr    (r_head),
        .o_rdata    (tape_rdata),
        .o_clr_busy (clr_busy)
    );

    tmse_rule_ram u_rule (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rule_wr),
        .i_raddr ({r_mstate, tape_rdata}),
        .o_rdata (rule_rdata),
        .o_rdef  (rule_rdef)
    );

    assign o_in_ready = (r_fsm == S_IDLE) && !clr_busy && (!r_out_vld || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_fsm       = r_fsm;
        n_mstate    = r_mstate;
        n_head      = r_head;
        n_steps     = r_steps;
        n_running   = r_running;
        n_rd        = r_rd;
        emit        = 1'b0;
        emit_status = r_running ? ST_RUN : ST_IDLE;
        emit_rd     = '0;
        emit_wr     = '0;
        step_status = ST_RUN;

        tape_wr.en     = 1'b0;
        tape_wr.addr   = i_in_data.cell_index;
        tape_wr.data   = i_in_data.cell_symbol;
        rule_wr.en     = 1'b0;
        rule_wr.addr   = {i_in_data.rule_state, i_in_data.rule_symbol};
        rule_wr.entry  = '{sym:  i_in_data.write_symbol,
                           move: i_in_data.head_move,
                           next: i_in_data.next_state};
        rule_wr.defined = i_in_data.rule_defined;

        case (r_fsm)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.command)
                        CMD_LOAD_RULE: begin
                            rule_wr.en = 1'b1;
                            emit       = 1'b1;
                        end
                        CMD_LOAD_CELL: begin
                            tape_wr.en = 1'b1;
                            emit       = 1'b1;
                        end
                        CMD_START: begin
                            n_head      = (i_in_data.head_start > TAPE_LAST) ?
                                          TAPE_LAST : i_in_data.head_start;
                            n_mstate    = STATE_START;
                            n_steps     = '0;
                            n_running   = 1'b1;
                            emit        = 1'b1;
                            emit_status = ST_RUN;
                        end
                        CMD_STEP: begin
                            if (r_running) begin
                                n_fsm = S_TAPE;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_TAPE: begin
                // The symbol under the head is here; the rule read is in flight.
                n_rd  = tape_rdata;
                n_fsm = S_RULE;
            end
            S_RULE: begin
                n_fsm   = S_IDLE;
                emit    = 1'b1;
                emit_rd = r_rd;
                if (!rule_rdef) begin
                    n_running   = 1'b0;
                    emit_status = ST_NORULE;
                end else begin
                    tape_wr.en   = 1'b1;
                    tape_wr.addr = r_head;
                    tape_wr.data = rule_rdata.sym;
                    emit_wr      = rule_rdata.sym;
                    n_mstate     = rule_rdata.next;
                    n_steps      = r_steps + 1'b1;
                    if (rule_rdata.move == MOVE_RIGHT) begin
                        if (r_head == TAPE_LAST) begin
                            step_status = ST_RIGHT;
                        end else begin
                            n_head = r_head + 1'b1;
                        end
                    end else if (rule_rdata.move == MOVE_LEFT) begin
                        if (r_head == '0) begin
                            step_status = ST_LEFT;
                        end else begin
                            n_head = r_head - 1'b1;
                        end
                    end
                    // Halt wins over a border error; the limit only applies otherwise.
                    if (rule_rdata.next == STATE_HALT) begin
                        step_status = ST_HALT;
                    end else if (step_status == ST_RUN && n_steps >= r_max_steps) begin
                        step_status = ST_LIMIT;
                    end
                    if (step_status != ST_RUN) begin
                        n_running = 1'b0;
                    end
                    emit_status = step_status;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase

        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        if (emit) begin
            n_out_vld = 1'b1;
            n_out     = '{status:         emit_status,
                          state_now:      n_mstate,
                          head_now:       n_head,
                          read_symbol:    emit_rd,
                          written_symbol: emit_wr,
                          steps_done:     n_steps};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_mstate    <= '0;
            r_head      <= '0;
            r_steps     <= '0;
            r_running   <= 1'b0;
            r_out_vld   <= 1'b0;
            r_max_steps <= MAX_STEPS_RST;
        end else begin
            r_fsm     <= n_fsm;
            r_mstate  <= n_mstate;
            r_head    <= n_head;
            r_steps   <= n_steps;
            r_running <= n_running;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_max_steps <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= n_rd;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== design/tmse_checker.sv =====
// ----------------------------------------------------------------------------
// tmse_checker
// Port-level checks on the step engine, bound to the top level.
// ----------------------------------------------------------------------------
module tmse_checker
    import tmse_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output beat pending after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Input is only taken when the output register has room.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("input taken while a result waits");

    // Every command other than a step answers in the next cycle.
    a_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command != CMD_STEP |=> o_out_valid)
        else $error("load or start gave no result beat");

    // A run starts in state one with a zero step count.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command == CMD_START |=>
            o_out_data.status == ST_RUN && o_out_data.state_now == STATE_START &&
            o_out_data.steps_done == '0)
        else $error("start result is wrong");

endmodule

bind turing_machine_step_engine_core tmse_checker u_tmse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the Turing machine step engine against a cycle-free machine model
// kept in the bench. A short directed run covers idle steps, every stop
// reason and a mid-run step limit change. Random programs of rule loads, tape
// loads, starts and steps then run under several step limits, with random
// sender bursts, receiver stalls and long output hold-offs.
// ----------------------------------------------------------------------------
module testbench;
    import tmse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 130;
    localparam int HOLD_CYCLES = 250;
    localparam int MAX_PRINTS  = 40;

    localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_CODE3 = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_we = 1'b0;
    logic [STEP_W-1:0] i_cfg_data = '0;

    turing_machine_step_engine_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Machine model state.
    t_rule_entry         rule_mem [RULE_DEPTH];
    logic                rule_ok  [RULE_DEPTH];
    logic [SYM_W-1:0]    tape_mem [TAPE_CELLS];
    logic [STATE_W-1:0]  mach_state;
    logic [TAPE_AW-1:0]  head_pos;
    logic [STEP_W-1:0]   step_cnt;
    logic                run_active;
    logic [STEP_W-1:0]   step_limit;

    t_in_item  cmds_to_send [$];
    t_out_item reports_due [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  results_seen = 0;
    int  phase_count = 0;
    bit  in_taken = 1'b0;

    // Sender and receiver pacing.
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int hold_mark = 300;
    int rx_mode = 0;
    int rx_mode_left = 0;

    function automatic t_out_item advance_machine(t_in_item it);
        t_out_item          r;
        t_rule_entry        ru;
        logic [SYM_W-1:0]   rd;
        logic [RULE_AW-1:0] slot;
        logic [STATUS_W-1:0] st;
        r = '0;
        case (it.command)
            CMD_LOAD_RULE: begin
                slot = {it.rule_state, it.rule_symbol};
                rule_mem[slot].sym  = it.write_symbol;
                rule_mem[slot].move = it.head_move;
                rule_mem[slot].next = it.next_state;
                rule_ok[slot] = it.rule_defined;
                r.status = run_active ? ST_RUN : ST_IDLE;
            end
            CMD_LOAD_CELL: begin
                tape_mem[it.cell_index] = it.cell_symbol;
                r.status = run_active ? ST_RUN : ST_IDLE;
            end
            CMD_START: begin
                head_pos   = it.head_start;
                mach_state = STATE_START;
                step_cnt   = '0;
                run_active = 1'b1;
                r.status   = ST_RUN;
            end
            default: begin
                if (!run_active) begin
                    r.status = ST_IDLE;
                end else begin
                    rd = tape_mem[head_pos];
                    slot = {mach_state, rd};
                    r.read_symbol = rd;
                    if (!rule_ok[slot]) begin
                        run_active = 1'b0;
                        r.status = ST_NORULE;
                    end else begin
                        ru = rule_mem[slot];
                        tape_mem[head_pos] = ru.sym;
                        mach_state = ru.next;
                        step_cnt = step_cnt + 1'b1;
                        st = ST_RUN;
                        if (ru.move == MOVE_RIGHT) begin
                            if (head_pos == TAPE_LAST) st = ST_RIGHT;
                            else head_pos = head_pos + 1'b1;
                        end else if (ru.move == MOVE_LEFT) begin
                            if (head_pos == '0) st = ST_LEFT;
                            else head_pos = head_pos - 1'b1;
                        end
                        // A halt wins over a border stop.
                        if (mach_state == STATE_HALT) st = ST_HALT;
                        else if (st == ST_RUN && step_cnt >= step_limit) st = ST_LIMIT;
                        if (st != ST_RUN) run_active = 1'b0;
                        r.status = st;
                        r.written_symbol = ru.sym;
                    end
                end
            end
        endcase
        r.state_now  = mach_state;
        r.head_now   = head_pos;
        r.steps_done = step_cnt;
        return r;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR: beat %0d %s got %0d expected %0d",
                     results_seen, what, got, want);
    endtask

    task automatic check_report(input t_out_item got, input t_out_item want);
        if (got.status !== want.status)
            flag_error("status", 32'(got.status), 32'(want.status));
        if (got.state_now !== want.state_now)
            flag_error("state_now", 32'(got.state_now), 32'(want.state_now));
        if (got.head_now !== want.head_now)
            flag_error("head_now", 32'(got.head_now), 32'(want.head_now));
        if (got.read_symbol !== want.read_symbol)
            flag_error("read_symbol", 32'(got.read_symbol), 32'(want.read_symbol));
        if (got.written_symbol !== want.written_symbol)
            flag_error("written_symbol", 32'(got.written_symbol),
                       32'(want.written_symbol));
        if (got.steps_done !== want.steps_done)
            flag_error("steps_done", 32'(got.steps_done), 32'(want.steps_done));
    endtask

    // Input side: accepted beats and register writes update the model.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RULE_DEPTH; k++) begin
                rule_mem[RULE_AW'(k)] = '0;
                rule_ok[RULE_AW'(k)] = 1'b0;
            end
            for (int k = 0; k < TAPE_CELLS; k++) tape_mem[TAPE_AW'(k)] = '0;
            mach_state = '0;
            head_pos   = '0;
            step_cnt   = '0;
            run_active = 1'b0;
            step_limit = MAX_STEPS_RST;
            in_taken   = 1'b0;
        end else begin
            if (i_cfg_we) step_limit = i_cfg_data;
            in_taken = i_in_valid && o_in_ready;
            if (in_taken) reports_due.push_back(advance_machine(i_in_data));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (reports_due.size() == 0) flag_error("unexpected beat", 0, 0);
            else check_report(o_out_data, reports_due.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (cmds_to_send.size() != 0) begin
                i_in_data  <= cmds_to_send.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (results_seen >= hold_mark) begin
            // Long hold-off: the sender keeps going so the engine backs up.
            hold_left = HOLD_CYCLES;
            hold_mark += 600;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 150);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 1);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_in_item random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    task automatic queue_beat(input t_in_item it);
        cmds_to_send.push_back(it);
        phase_count++;
    endtask

    task automatic queue_rule(input int s, input int y, input int w, input int m,
                              input int n, input int d);
        t_in_item it;
        it = random_item();
        it.command      = CMD_LOAD_RULE;
        it.rule_state   = STATE_W'(s);
        it.rule_symbol  = SYM_W'(y);
        it.write_symbol = SYM_W'(w);
        it.head_move    = MOVE_W'(m);
        it.next_state   = STATE_W'(n);
        it.rule_defined = 1'(d);
        queue_beat(it);
    endtask

    task automatic queue_cell(input int c, input int v);
        t_in_item it;
        it = random_item();
        it.command     = CMD_LOAD_CELL;
        it.cell_index  = TAPE_AW'(c);
        it.cell_symbol = SYM_W'(v);
        queue_beat(it);
    endtask

    task automatic queue_start(input int h);
        t_in_item it;
        it = random_item();
        it.command    = CMD_START;
        it.head_start = TAPE_AW'(h);
        queue_beat(it);
    endtask

    task automatic queue_step();
        t_in_item it;
        it = random_item();
        it.command = CMD_STEP;
        queue_beat(it);
    endtask

    task automatic queue_program();
        int n_states, n_syms, start_at, lo, hi, nxt;
        // Now and then no start, so a run carries over a step limit change.
        if ($urandom_range(0, 3) != 0) begin
            n_states = $urandom_range(2, 6);
            n_syms   = $urandom_range(2, 4);
            for (int s = 1; s <= n_states; s++) begin
                for (int y = 0; y < n_syms; y++) begin
                    if ($urandom_range(0, 2) != 0) begin
                        nxt = ($urandom_range(0, 19) == 0) ? int'(STATE_HALT)
                                                           : $urandom_range(1, n_states);
                        queue_rule(s, y, $urandom_range(0, n_syms - 1),
                                   $urandom_range(0, 3), nxt,
                                   int'($urandom_range(0, 24) != 0));
                    end
                end
            end
            case ($urandom_range(0, 3))
                0: start_at = $urandom_range(0, 4);
                1: start_at = $urandom_range(TAPE_CELLS - 5, TAPE_CELLS - 1);
                default: start_at = $urandom_range(0, TAPE_CELLS - 1);
            endcase
            lo = (start_at < 3) ? 0 : start_at - 3;
            hi = (start_at > TAPE_CELLS - 4) ? TAPE_CELLS - 1 : start_at + 3;
            for (int c = lo; c <= hi; c++)
                if ($urandom_range(0, 1) == 1) queue_cell(c, $urandom_range(0, n_syms - 1));
            queue_start(start_at);
        end
        repeat ($urandom_range(3, 50)) begin
            if ($urandom_range(0, 11) == 0) queue_beat(random_item());
            else queue_step();
        end
    endtask

    task automatic wait_drained();
        while (cmds_to_send.size() != 0 || i_in_valid || reports_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_step_limit(input int v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= STEP_W'(v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    int limits [] = '{65535, 0, 12, 40, 3, 1000, 25, 65535, 7, 100, 2};

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_step();                                   // step with no run
        queue_cell(TAPE_CELLS - 1, 15);
        queue_cell(0, 14);
        queue_rule(1, 0, 5, int'(MOVE_RIGHT), 2, 1);
        queue_rule(2, 0, 9, int'(MOVE_LEFT), 1, 1);
        queue_rule(1, 5, 3, int'(MOVE_CODE3), 15, 1);
        queue_rule(15, 3, 15, int'(MOVE_RIGHT), 15, 0); // explicitly undefined
        queue_rule(1, 15, 15, int'(MOVE_RIGHT), 4, 1);
        queue_rule(1, 14, 13, int'(MOVE_LEFT), 6, 1);
        queue_rule(1, 13, 0, int'(MOVE_LEFT), int'(STATE_HALT), 1);
        queue_rule(1, 9, 9, int'(MOVE_STAY), 1, 1);
        queue_start(10);
        queue_step();
        queue_cell(500, 7);                             // load during a run
        queue_step();
        queue_step();
        queue_step();                                   // no rule for state 15
        queue_start(TAPE_CELLS - 1);
        queue_step();                                   // right border
        queue_start(0);
        queue_step();                                   // left border
        queue_start(0);
        queue_step();                                   // halt beats left border
        queue_start(11);
        queue_step();
        queue_step();
        wait_drained();
        // Lower the limit under a live run.
        write_step_limit(1);
        queue_step();
        queue_step();

        foreach (limits[p]) begin
            wait_drained();
            write_step_limit(limits[p]);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) queue_program();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tmse_pkg.sv
design/tmse_tape_ram.sv
design/tmse_rule_ram.sv
design/turing_machine_step_engine_core.sv
design/tmse_checker.sv
tb/sv/testbench.sv
